[src/aesd_pkg.sv]
package aesd_pkg;

  localparam int CAL_W     = 12;
  localparam int TIMEOUT_W = 11;
  localparam int OUT_W     = 16;
  localparam int LED_W     = 4;

  typedef enum logic [1:0] {
    MODE_POT  = 2'd0,
    MODE_VOLT = 2'd1,
    MODE_TEMP = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    OP_POT  = 2'd0,
    OP_LED  = 2'd1,
    OP_MODE = 2'd2
  } div_op_t;

  typedef enum logic [1:0] {
    CFG_TEMP_CAL_LOW  = 2'd0,
    CFG_TEMP_CAL_HIGH = 2'd1,
    CFG_VREF_CAL      = 2'd2,
    CFG_MODE_TIMEOUT  = 2'd3
  } cfg_index_t;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic [CAL_W-1:0]     TEMP_CAL_LOW_RESET  = 12'd1750;
  localparam logic [CAL_W-1:0]     TEMP_CAL_HIGH_RESET = 12'd1330;
  localparam logic [CAL_W-1:0]     VREF_CAL_RESET      = 12'd1526;
  localparam logic [TIMEOUT_W-1:0] MODE_TIMEOUT_RESET  = 11'd1000;
  localparam logic [TIMEOUT_W-1:0] TICK_MAX            = 11'd2047;

  localparam int POT_SCALE  = 100;
  localparam int POT_DIV    = 819;
  localparam int LED_SCALE  = 9;
  localparam int LED_DIV    = 500;
  localparam int VOLT_SCALE = 330;
  localparam int TEMP_SPAN  = 80;
  localparam int TEMP_BASE  = 30;

  typedef struct packed {
    logic    take_sample;
    logic    take_tick;
    logic    div_start;
    div_op_t div_op;
    logic    load_out;
  } aesd_cmd_t;

  typedef struct packed {
    logic div_done;
    logic need_mode;
  } aesd_status_t;

endpackage

[src/aesd_divider.sv]
module aesd_divider #(
  parameter int W = 22
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  // two quotient bits per cycle
  localparam int STEPS = W / 2;
  localparam int CW    = $clog2(STEPS + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  den;
  logic [CW-1:0] count;
  logic [W-1:0]  rem_next;
  logic [W-1:0]  quo_next;
  logic [W:0]    trial;

  always_comb begin
    rem_next = rem;
    quo_next = quo;
    trial    = '0;
    for (int i = 0; i < 2; i++) begin
      trial    = {rem_next, quo_next[W-1]};
      quo_next = {quo_next[W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        trial       = trial - {1'b0, den};
        quo_next[0] = 1'b1;
      end
      rem_next = trial[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= CW'(STEPS);
      end else if (count != '0) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      den <= divisor;
    end else if (count != '0) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

endmodule

[src/aesd_datapath.sv]
module aesd_datapath #(
  parameter int NUM_CHANNELS = 3,
  parameter int FILTER_SHIFT = 6,
  parameter int SAMPLE_BITS  = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  aesd_pkg::aesd_cmd_t            cmd,
  output aesd_pkg::aesd_status_t         status,
  input  logic [SAMPLE_BITS-1:0]         sample,
  input  logic                           end_of_sequence,
  input  logic                           temp_button,
  input  logic                           volt_button,
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [aesd_pkg::CAL_W-1:0]     cfg_data,
  output logic [aesd_pkg::OUT_W-1:0]     display_value,
  output logic [aesd_pkg::LED_W-1:0]     led_count,
  output logic [1:0]                     display_mode,
  output logic                           divide_error
);

  import aesd_pkg::*;

  localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ACC_W   = SAMPLE_BITS + FILTER_SHIFT;
  localparam int POT_W   = SAMPLE_BITS - 2;
  localparam int DEN_W   = (SAMPLE_BITS > CAL_W) ? SAMPLE_BITS : CAL_W;
  localparam int DIFF_W  = DEN_W + 1;
  localparam int DIV_RAW = (DEN_W + 7 > 21) ? DEN_W + 7 : 21;
  localparam int DIV_W   = DIV_RAW + (DIV_RAW % 2);

  logic [ACC_W-1:0]       acc [NUM_CHANNELS];
  logic [SAMPLE_BITS-1:0] filt [NUM_CHANNELS];
  logic [CH_W-1:0]        chan;
  mode_t                  mode;
  logic [TIMEOUT_W-1:0]   ticks;
  logic [CAL_W-1:0]       cal_low;
  logic [CAL_W-1:0]       cal_high;
  logic [CAL_W-1:0]       vref;
  logic [TIMEOUT_W-1:0]   timeout;
  logic [POT_W-1:0]       pot_q;
  logic [LED_W-1:0]       led_q;
  logic [OUT_W-1:0]       mode_q;

  logic [ACC_W-1:0]       acc_sel;
  logic [ACC_W-1:0]       acc_next;
  logic [SAMPLE_BITS-1:0] filt_next;
  logic [CH_W-1:0]        chan_next;
  mode_t                  mode_next;
  logic [TIMEOUT_W-1:0]   ticks_next;

  logic [SAMPLE_BITS-1:0] f0;
  logic [SAMPLE_BITS-1:0] f1;
  logic [SAMPLE_BITS-1:0] f2;

  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        diff_abs;
  logic signed [CAL_W:0]    span;
  logic [CAL_W:0]           span_abs;
  logic                     temp_neg;
  logic                     div_zero;
  logic [DIV_W-1:0]         div_num;
  logic [DIV_W-1:0]         div_den;
  logic [DIV_W-1:0]         quotient;
  logic                     div_done;
  logic [OUT_W-1:0]         q16;

  // moving average update for the current channel
  assign acc_sel   = acc[chan];
  assign filt_next = acc_sel[ACC_W-1:FILTER_SHIFT];
  assign acc_next  = acc_sel - ACC_W'(filt_next) + ACC_W'(sample);
  assign chan_next = end_of_sequence ? '0 :
                     (chan < CH_W'(NUM_CHANNELS - 1)) ? chan + 1'b1 : chan;

  assign f0 = filt[0];
  if (NUM_CHANNELS > 1) begin : g_f1
    assign f1 = filt[1];
  end else begin : g_no_f1
    assign f1 = '0;
  end
  if (NUM_CHANNELS > 2) begin : g_f2
    assign f2 = filt[2];
  end else begin : g_no_f2
    assign f2 = '0;
  end

  always_comb begin
    ticks_next = (ticks == TICK_MAX) ? ticks : ticks + 1'b1;
    mode_next  = mode;
    if (mode == MODE_POT && temp_button) begin
      mode_next  = MODE_TEMP;
      ticks_next = '0;
    end else if (mode == MODE_POT && volt_button) begin
      mode_next  = MODE_VOLT;
      ticks_next = '0;
    end
    if (ticks_next > timeout) begin
      mode_next = MODE_POT;
    end
  end

  // signed temperature operands as magnitude and sign
  assign diff     = $signed({1'b0, DEN_W'(f1)}) - $signed({1'b0, DEN_W'(cal_low)});
  assign diff_abs = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
  assign span     = $signed({1'b0, cal_high}) - $signed({1'b0, cal_low});
  assign span_abs = span[CAL_W] ? (~span + 1'b1) : span;
  assign temp_neg = diff[DIFF_W-1] ^ span[CAL_W];

  assign div_zero = (mode == MODE_VOLT) ? (f2 == '0) : (span_abs == '0);
  assign status.need_mode = (mode != MODE_POT) && !div_zero;
  assign status.div_done  = div_done;

  always_comb begin
    case (cmd.div_op)
      OP_POT: begin
        div_num = DIV_W'(f0) * DIV_W'(POT_SCALE);
        div_den = DIV_W'(POT_DIV);
      end
      OP_LED: begin
        div_num = DIV_W'(pot_q) * DIV_W'(LED_SCALE);
        div_den = DIV_W'(LED_DIV);
      end
      OP_MODE: begin
        if (mode == MODE_VOLT) begin
          div_num = DIV_W'(vref) * DIV_W'(VOLT_SCALE);
          div_den = DIV_W'(f2);
        end else begin
          div_num = DIV_W'(diff_abs[DEN_W-1:0]) * DIV_W'(TEMP_SPAN);
          div_den = DIV_W'(span_abs[CAL_W-1:0]);
        end
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  aesd_divider #(
    .W(DIV_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (quotient)
  );

  assign q16 = quotient[OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        acc[i]  <= '0;
        filt[i] <= '0;
      end
      chan     <= '0;
      mode     <= MODE_POT;
      ticks    <= '0;
      cal_low  <= TEMP_CAL_LOW_RESET;
      cal_high <= TEMP_CAL_HIGH_RESET;
      vref     <= VREF_CAL_RESET;
      timeout  <= MODE_TIMEOUT_RESET;
    end else begin
      if (cmd.take_sample) begin
        acc[chan]  <= acc_next;
        filt[chan] <= filt_next;
        chan       <= chan_next;
      end
      if (cmd.take_tick) begin
        mode  <= mode_next;
        ticks <= ticks_next;
      end
      if (cfg_write) begin
        case (cfg_index_t'(cfg_index))
          CFG_TEMP_CAL_LOW:  cal_low  <= cfg_data;
          CFG_TEMP_CAL_HIGH: cal_high <= cfg_data;
          CFG_VREF_CAL:      vref     <= cfg_data;
          CFG_MODE_TIMEOUT:  timeout  <= cfg_data[TIMEOUT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_done) begin
      case (cmd.div_op)
        OP_POT:  pot_q <= quotient[POT_W-1:0];
        OP_LED:  led_q <= quotient[LED_W-1:0];
        OP_MODE: begin
          if (mode == MODE_VOLT) begin
            mode_q <= q16;
          end else begin
            mode_q <= (temp_neg ? (~q16 + 1'b1) : q16) + OUT_W'(TEMP_BASE);
          end
        end
        default: ;
      endcase
    end
    if (cmd.load_out) begin
      display_value <= (mode == MODE_POT) ? OUT_W'(pot_q) : (div_zero ? '0 : mode_q);
      led_count     <= led_q;
      display_mode  <= mode;
      divide_error  <= (mode != MODE_POT) && div_zero;
    end
  end

endmodule

[src/aesd_ctrl.sv]
module aesd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   command,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  aesd_pkg::aesd_status_t status,
  output aesd_pkg::aesd_cmd_t    cmd
);

  import aesd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POT,
    ST_LED,
    ST_MODE,
    ST_DONE
  } state_t;

  state_t  state;
  logic    div_start;
  div_op_t div_op;
  logic    take_sample;
  logic    take_tick;
  logic    load_out;

  assign in_stall    = (state != ST_IDLE);
  assign take_sample = (state == ST_IDLE) && in_valid && (command == CMD_SAMPLE);
  assign take_tick   = (state == ST_IDLE) && in_valid && (command == CMD_TICK);
  assign load_out    = (state == ST_DONE) && (!out_valid || !out_stall);

  assign cmd.take_sample = take_sample;
  assign cmd.take_tick   = take_tick;
  assign cmd.div_start   = div_start;
  assign cmd.div_op      = div_op;
  assign cmd.load_out    = load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_start <= 1'b0;
      div_op    <= OP_POT;
      out_valid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (take_sample) begin
            state     <= ST_POT;
            div_start <= 1'b1;
            div_op    <= OP_POT;
          end
        end
        ST_POT: begin
          if (status.div_done) begin
            state     <= ST_LED;
            div_start <= 1'b1;
            div_op    <= OP_LED;
          end
        end
        ST_LED: begin
          if (status.div_done) begin
            if (status.need_mode) begin
              state     <= ST_MODE;
              div_start <= 1'b1;
              div_op    <= OP_MODE;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_MODE: begin
          if (status.div_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[src/adc_ema_sensor_display_unit.sv]
// each sample runs the shared 2-bit-per-cycle divider for pot, led and mode
// values in turn, skipping mode in pot mode or on a zero divisor
// one tick per cycle while idle; a sample stalls input until its result loads
// results wait in an output register; the next item is taken while one waits
// rst is synchronous: filters, channel index, mode, ticks and calibration reset
module adc_ema_sensor_display_unit #(
  parameter int NUM_CHANNELS = 3,
  parameter int FILTER_SHIFT = 6,
  parameter int SAMPLE_BITS  = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       command,
  input  logic [SAMPLE_BITS-1:0]     sample,
  input  logic                       end_of_sequence,
  input  logic                       temp_button,
  input  logic                       volt_button,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [aesd_pkg::OUT_W-1:0] display_value,
  output logic [aesd_pkg::LED_W-1:0] led_count,
  output logic [1:0]                 display_mode,
  output logic                       divide_error,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [aesd_pkg::CAL_W-1:0] cfg_data
);

  import aesd_pkg::*;

  aesd_cmd_t    cmd;
  aesd_status_t status;

  assign cfg_ready = 1'b1;

  aesd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .command   (command),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  aesd_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .FILTER_SHIFT (FILTER_SHIFT),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .sample          (sample),
    .end_of_sequence (end_of_sequence),
    .temp_button     (temp_button),
    .volt_button     (volt_button),
    .cfg_write       (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .display_value   (display_value),
    .led_count       (led_count),
    .display_mode    (display_mode),
    .divide_error    (divide_error)
  );

endmodule

[src/aesd_checker.sv]
module aesd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       command,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [aesd_pkg::OUT_W-1:0] display_value,
  input logic [1:0]                 display_mode,
  input logic                       divide_error
);

  import aesd_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(display_value) && $stable(display_mode))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_error |-> display_value == '0)
    else $error("divide error with nonzero value");

  a_pot_no_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && display_mode == MODE_POT |-> !divide_error)
    else $error("divide error in pot mode");

  // a sample keeps the block busy for its computation
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command == CMD_SAMPLE |=> in_stall)
    else $error("input taken right after a sample");

endmodule

bind adc_ema_sensor_display_unit aesd_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .command       (command),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .display_value (display_value),
  .display_mode  (display_mode),
  .divide_error  (divide_error)
);
